FILE: rtl/graded_interface_profile_core_macros.svh
// Assertion macros shared by the graded interface profile RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef GRADED_INTERFACE_PROFILE_CORE_MACROS_SVH
`define GRADED_INTERFACE_PROFILE_CORE_MACROS_SVH

`define GIP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define GIP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/gip_pkg.sv
// Package for the graded interface profile core: sizes, types, codes and the weight table.
// Used by the core, the weight unit and the verification modules; depends on nothing.
package gip_pkg;

    localparam int MAX_LAYERS       = 64;
    localparam int TANH_TABLE_DEPTH = 256;
    localparam int LAYER_AW         = $clog2(MAX_LAYERS);
    localparam int CNT_W            = $clog2(MAX_LAYERS + 1);
    localparam int TANH_AW          = $clog2(TANH_TABLE_DEPTH);
    localparam int STEP_W           = $clog2(TANH_AW);
    localparam int LC_W             = 7;
    localparam int W_W              = 17;
    localparam int U_LIMIT_SH       = 19;
    localparam int DIV_W            = 51;
    localparam int PREF_Q16         = 52290;
    localparam int ONE_Q16          = 65536;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [5:0]        entry_index;
        logic signed [31:0] density_real;
        logic signed [31:0] density_imag;
        logic signed [31:0] bottom_depth;
        logic signed [31:0] roughness;
        logic signed [31:0] depth_query;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] profile_real;
        logic signed [31:0] profile_imag;
        logic              saturated;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] density_real;
        logic signed [31:0] density_imag;
        logic signed [31:0] depth;
        logic signed [31:0] roughness;
    } entry_t;

    typedef struct packed {
        logic              start;
        logic signed [32:0] x;
        logic signed [31:0] sigma;
    } wreq_t;

    typedef struct packed {
        logic             done;
        logic [W_W-1:0]   w;
    } wrsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH0,
        ST_NEXT,
        ST_WAIT,
        ST_MAC,
        ST_ADD,
        ST_FINISH
    } seq_state_t;

    typedef enum logic [2:0] {
        W_IDLE,
        W_MUL,
        W_CHK,
        W_DIV,
        W_ROM
    } wgt_state_t;

    typedef logic [15:0] wrom_t [TANH_TABLE_DEPTH];

    // Unsigned long division used only while the weight table is built.
    function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Samples of (1 - tanh(t)) / 2 over [0, 8), built as q / (1 + q) with q = exp(-2t).
    function automatic wrom_t build_rom();
        logic [63:0] one;
        logic [63:0] s;
        logic [63:0] term;
        logic [63:0] q;
        logic [63:0] r;
        longint      acc;
        wrom_t       rom;
        one  = 64'd1 << 32;
        s    = udiv64(64'd1 << 36, 64'(TANH_TABLE_DEPTH));
        term = one;
        acc  = longint'(one);
        q    = one;
        for (int n = 1; n <= 24; n++) begin
            term = udiv64((term * s) >> 32, 64'(n));
            if ((n & 1) != 0) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        r = (acc < 0) ? 64'd0 : 64'(acc);
        for (int k = 0; k < TANH_TABLE_DEPTH; k++) begin
            rom[k] = 16'(udiv64(q << 16, one + q));
            q = (q * r + (64'd1 << 31)) >> 32;
        end
        return rom;
    endfunction

    localparam wrom_t WROM = build_rom();

endpackage

FILE: rtl/gip_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Stand-alone; holds the layer table of the profile core.
module gip_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/gip_weight.sv
// Transition weight unit: scales the interface offset, divides by roughness one bit per cycle
// and looks up the tanh table. Depends on gip_pkg.
module gip_weight (
    input  logic          clk,
    input  logic          rst_n,
    input  gip_pkg::wreq_t req,
    output gip_pkg::wrsp_t rsp
);

    gip_pkg::wgt_state_t state_reg, state_next;
    logic                          done_reg, done_next;
    logic [gip_pkg::W_W-1:0]       w_reg, w_next;
    logic                          neg_reg, neg_next;
    logic [32:0]                   ax_reg, ax_next;
    logic [30:0]                   sig_reg, sig_next;
    logic [gip_pkg::DIV_W-1:0]     num_reg, num_next;
    logic [gip_pkg::DIV_W-1:0]     rem_reg, rem_next;
    logic [gip_pkg::DIV_W-1:0]     dsh_reg, dsh_next;
    logic [gip_pkg::TANH_AW-1:0]   quo_reg, quo_next;
    logic                          ovf_reg, ovf_next;
    logic [gip_pkg::STEP_W-1:0]    step_reg, step_next;
    logic                          fit;
    logic [15:0]                   wmag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gip_pkg::W_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg    <= w_next;
        neg_reg  <= neg_next;
        ax_reg   <= ax_next;
        sig_reg  <= sig_next;
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quo_reg  <= quo_next;
        ovf_reg  <= ovf_next;
        step_reg <= step_next;
    end

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        w_next     = w_reg;
        neg_next   = neg_reg;
        ax_next    = ax_reg;
        sig_next   = sig_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        dsh_next   = dsh_reg;
        quo_next   = quo_reg;
        ovf_next   = ovf_reg;
        step_next  = step_reg;
        fit        = rem_reg >= dsh_reg;
        wmag       = ovf_reg ? 16'd0 : gip_pkg::WROM[quo_reg];
        case (state_reg)
            gip_pkg::W_IDLE:
            begin
                if (req.start)
                begin
                    neg_next = req.x < 0;
                    ax_next  = (req.x < 0) ? 33'(-req.x) : 33'(req.x);
                    sig_next = req.sigma[30:0];
                    if (req.sigma <= 0)
                    begin
                        w_next    = (req.x < 0) ? gip_pkg::W_W'(gip_pkg::ONE_Q16)
                                                : '0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        state_next = gip_pkg::W_MUL;
                    end
                end
            end
            gip_pkg::W_MUL:
            begin
                num_next   = gip_pkg::DIV_W'(ax_reg * 16'(gip_pkg::PREF_Q16));
                state_next = gip_pkg::W_CHK;
            end
            gip_pkg::W_CHK:
            begin
                ovf_next   = num_reg >= (gip_pkg::DIV_W'(sig_reg) << gip_pkg::U_LIMIT_SH);
                rem_next   = num_reg;
                dsh_next   = gip_pkg::DIV_W'(sig_reg) << (gip_pkg::U_LIMIT_SH - 1);
                quo_next   = '0;
                step_next  = gip_pkg::STEP_W'(gip_pkg::TANH_AW - 1);
                state_next = gip_pkg::W_DIV;
            end
            gip_pkg::W_DIV:
            begin
                if (fit)
                begin
                    rem_next = rem_reg - dsh_reg;
                end
                quo_next  = {quo_reg[gip_pkg::TANH_AW-2:0], fit};
                dsh_next  = dsh_reg >> 1;
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    state_next = gip_pkg::W_ROM;
                end
            end
            gip_pkg::W_ROM:
            begin
                w_next     = neg_reg ? gip_pkg::W_W'(gip_pkg::ONE_Q16 - int'(wmag))
                                     : gip_pkg::W_W'(wmag);
                done_next  = 1'b1;
                state_next = gip_pkg::W_IDLE;
            end
            default:
            begin
                state_next = gip_pkg::W_IDLE;
            end
        endcase
    end

    assign rsp.done = done_reg;
    assign rsp.w    = w_reg;

endmodule

FILE: rtl/graded_interface_profile_core.sv
// A query walks the layer table entry by entry; a sharp interface takes its weight without a
// division, a rough one waits on the bit-serial roughness division in the weight unit.
// Loads are accepted back to back while idle; one query is evaluated at a time.
// Reset is asynchronous and active low; it clears the layer count and the sequencer.
// The layer table has no reset and must be loaded before it is queried.
`include "graded_interface_profile_core_macros.svh"

module graded_interface_profile_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [6:0]         cfg_wr_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  gip_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output gip_pkg::out_item_t out_data
);

    gip_pkg::seq_state_t state_reg, state_next;
    logic [gip_pkg::LC_W-1:0]   layer_count_reg;
    logic [gip_pkg::CNT_W-1:0]  n_reg, n_next;
    logic [gip_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic signed [31:0]         z_reg, z_next;
    gip_pkg::entry_t            prev_reg, prev_next;
    gip_pkg::entry_t            cur_reg, cur_next;
    logic signed [32:0]         dr_reg, dr_next;
    logic signed [32:0]         di_reg, di_next;
    logic [gip_pkg::W_W-1:0]    w_reg, w_next;
    logic signed [50:0]         prod_re_reg, prod_re_next;
    logic signed [50:0]         prod_im_reg, prod_im_next;
    logic signed [63:0]         acc_re_reg, acc_re_next;
    logic signed [63:0]         acc_im_reg, acc_im_next;
    logic                       out_valid_reg, out_valid_next;
    gip_pkg::out_item_t         out_data_reg, out_data_next;

    logic                          ram_we;
    logic [gip_pkg::LAYER_AW-1:0]  ram_waddr;
    gip_pkg::entry_t               ram_wdata;
    logic                          ram_re;
    logic [gip_pkg::LAYER_AW-1:0]  ram_raddr;
    gip_pkg::entry_t               ram_rdata;
    gip_pkg::wreq_t                wreq;
    gip_pkg::wrsp_t                wrsp;
    logic                          accept;
    logic signed [63:0]            sum_re, sum_im;
    logic signed [47:0]            v_re, v_im;
    logic                          hi_re, lo_re, hi_im, lo_im;

    gip_ram #(
        .WIDTH ($bits(gip_pkg::entry_t)),
        .DEPTH (gip_pkg::MAX_LAYERS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    gip_weight u_weight (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (wreq),
        .rsp   (wrsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= gip_pkg::ST_IDLE;
            layer_count_reg <= '0;
            out_valid_reg   <= 1'b0;
            cnt_reg         <= '0;
            n_reg           <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            n_reg         <= n_next;
            if (cfg_wr_en)
            begin
                layer_count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        z_reg        <= z_next;
        prev_reg     <= prev_next;
        cur_reg      <= cur_next;
        dr_reg       <= dr_next;
        di_reg       <= di_next;
        w_reg        <= w_next;
        prod_re_reg  <= prod_re_next;
        prod_im_reg  <= prod_im_next;
        acc_re_reg   <= acc_re_next;
        acc_im_reg   <= acc_im_next;
        out_data_reg <= out_data_next;
    end

    assign accept = in_valid && !in_stall;

    always_comb
    begin
        sum_re = acc_re_reg + 64'sd32768;
        sum_im = acc_im_reg + 64'sd32768;
        v_re   = sum_re[63:16];
        v_im   = sum_im[63:16];
        hi_re  = v_re > 48'sh0000_7FFF_FFFF;
        lo_re  = v_re < -48'sh0000_8000_0000;
        hi_im  = v_im > 48'sh0000_7FFF_FFFF;
        lo_im  = v_im < -48'sh0000_8000_0000;
    end

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        cnt_next       = cnt_reg;
        z_next         = z_reg;
        prev_next      = prev_reg;
        cur_next       = cur_reg;
        dr_next        = dr_reg;
        di_next        = di_reg;
        w_next         = w_reg;
        prod_re_next   = prod_re_reg;
        prod_im_next   = prod_im_reg;
        acc_re_next    = acc_re_reg;
        acc_im_next    = acc_im_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && out_stall;
        in_stall       = 1'b1;
        ram_we         = 1'b0;
        ram_waddr      = gip_pkg::LAYER_AW'(in_data.entry_index);
        ram_wdata      = {in_data.density_real, in_data.density_imag,
                          in_data.bottom_depth, in_data.roughness};
        ram_re         = 1'b0;
        ram_raddr      = '0;
        wreq.start     = 1'b0;
        wreq.x         = 33'(z_reg) - 33'(prev_reg.depth);
        wreq.sigma     = prev_reg.roughness;
        case (state_reg)
            gip_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (accept)
                begin
                    if (in_data.req_type == gip_pkg::REQ_LOAD)
                    begin
                        ram_we = int'(in_data.entry_index) < gip_pkg::MAX_LAYERS;
                    end
                    else
                    begin
                        z_next      = in_data.depth_query;
                        n_next      = (int'(layer_count_reg) > gip_pkg::MAX_LAYERS)
                                      ? gip_pkg::CNT_W'(gip_pkg::MAX_LAYERS)
                                      : gip_pkg::CNT_W'(layer_count_reg);
                        acc_re_next = '0;
                        acc_im_next = '0;
                        ram_re      = 1'b1;
                        if (layer_count_reg == '0)
                        begin
                            state_next = gip_pkg::ST_FINISH;
                        end
                        else
                        begin
                            state_next = gip_pkg::ST_FETCH0;
                        end
                    end
                end
            end
            gip_pkg::ST_FETCH0:
            begin
                prev_next   = ram_rdata;
                acc_re_next = {{16{ram_rdata.density_real[31]}}, ram_rdata.density_real, 16'd0};
                acc_im_next = {{16{ram_rdata.density_imag[31]}}, ram_rdata.density_imag, 16'd0};
                if (n_reg > gip_pkg::CNT_W'(1))
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = gip_pkg::LAYER_AW'(1);
                    cnt_next   = gip_pkg::CNT_W'(1);
                    state_next = gip_pkg::ST_NEXT;
                end
                else
                begin
                    state_next = gip_pkg::ST_FINISH;
                end
            end
            gip_pkg::ST_NEXT:
            begin
                cur_next   = ram_rdata;
                wreq.start = 1'b1;
                state_next = gip_pkg::ST_WAIT;
            end
            gip_pkg::ST_WAIT:
            begin
                dr_next = 33'(cur_reg.density_real) - 33'(prev_reg.density_real);
                di_next = 33'(cur_reg.density_imag) - 33'(prev_reg.density_imag);
                if (wrsp.done)
                begin
                    w_next     = wrsp.w;
                    state_next = gip_pkg::ST_MAC;
                end
            end
            gip_pkg::ST_MAC:
            begin
                prod_re_next = dr_reg * $signed({1'b0, w_reg});
                prod_im_next = di_reg * $signed({1'b0, w_reg});
                state_next   = gip_pkg::ST_ADD;
            end
            gip_pkg::ST_ADD:
            begin
                acc_re_next = acc_re_reg + 64'(prod_re_reg);
                acc_im_next = acc_im_reg + 64'(prod_im_reg);
                prev_next   = cur_reg;
                if ((cnt_reg + 1'b1) < n_reg)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = gip_pkg::LAYER_AW'(cnt_reg + 1'b1);
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = gip_pkg::ST_NEXT;
                end
                else
                begin
                    state_next = gip_pkg::ST_FINISH;
                end
            end
            gip_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_data_next.profile_real = hi_re ? 32'sh7FFF_FFFF :
                                                 lo_re ? 32'sh8000_0000 : v_re[31:0];
                    out_data_next.profile_imag = hi_im ? 32'sh7FFF_FFFF :
                                                 lo_im ? 32'sh8000_0000 : v_im[31:0];
                    out_data_next.saturated    = hi_re || lo_re || hi_im || lo_im;
                    out_valid_next             = 1'b1;
                    state_next                 = gip_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gip_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `GIP_ASSERT_SAME(a_cnt_in_range, state_reg == gip_pkg::ST_NEXT, cnt_reg < n_reg, "entry counter ran past the layer count")
    `GIP_ASSERT_SAME(a_done_when_waiting, wrsp.done, state_reg == gip_pkg::ST_WAIT, "weight result arrived while the sequencer was not waiting")
    `GIP_ASSERT_NEXT(a_finish_holds, state_reg == gip_pkg::ST_FINISH && out_valid_reg && out_stall, state_reg == gip_pkg::ST_FINISH && $stable(out_data_reg), "pending result was overwritten")

endmodule

FILE: verif/gip_profile_checker.sv
// Checker for the graded interface profile core: watches the register, input and output
// transactions, predicts each profile value and compares it field by field.
// Depends on gip_pkg for the transaction types, sizes and request codes.
module gip_profile_checker
    import gip_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_wr_en,
    input  logic [6:0] cfg_wr_data,
    input  logic      in_valid,
    input  logic      in_stall,
    input  in_item_t  in_data,
    input  logic      out_valid,
    input  logic      out_stall,
    input  out_item_t out_data,
    output int        errors,
    output int        pending,
    output int        checked,
    output int        clipped
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [15:0] tanh_rom [TANH_TABLE_DEPTH];
    longint      rho_re [MAX_LAYERS];
    longint      rho_im [MAX_LAYERS];
    longint      iface_depth [MAX_LAYERS];
    longint      iface_sigma [MAX_LAYERS];
    int unsigned layers_used;
    out_item_t   profile_q [$];

    initial
    begin
        longint unsigned one;
        longint unsigned step;
        longint unsigned term;
        longint unsigned q;
        longint unsigned r;
        longint          acc;
        one  = 64'd1 << 32;
        step = (64'd1 << 36) / TANH_TABLE_DEPTH;
        term = one;
        acc  = longint'(one);
        q    = one;
        for (int n = 1; n <= 24; n++)
        begin
            term = ((term * step) >> 32) / longint'(n);
            if (n % 2 == 1)
            begin
                acc = acc - longint'(term);
            end
            else
            begin
                acc = acc + longint'(term);
            end
        end
        r = (acc < 0) ? 64'd0 : longint'(acc);
        for (int k = 0; k < TANH_TABLE_DEPTH; k++)
        begin
            tanh_rom[k] = 16'((q << 16) / (one + q));
            q = (q * r + (64'd1 << 31)) >> 32;
        end
    end

    function automatic longint transition_weight(longint x, longint sigma);
        longint unsigned ax;
        longint unsigned u;
        longint          w;
        if (sigma <= 0)
        begin
            return (x < 0) ? longint'(ONE_Q16) : 64'sd0;
        end
        ax = (x < 0) ? -x : x;
        u  = ax * PREF_Q16 / longint'(sigma);
        if (u >= (64'd8 << 16))
        begin
            w = 0;
        end
        else
        begin
            w = tanh_rom[(u * TANH_TABLE_DEPTH) >> 19];
        end
        return (x < 0) ? ONE_Q16 - w : w;
    endfunction

    function automatic logic [31:0] round_clip(longint acc, inout logic clip);
        longint v;
        v = (acc + 32768) >>> 16;
        if (v > 64'sd2147483647)
        begin
            clip = 1'b1;
            return 32'h7fffffff;
        end
        if (v < -64'sd2147483648)
        begin
            clip = 1'b1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    function automatic out_item_t profile_at(longint z);
        int unsigned n;
        longint      re;
        longint      im;
        longint      w;
        logic        clip;
        out_item_t   res;
        n    = (layers_used > MAX_LAYERS) ? MAX_LAYERS : layers_used;
        re   = 0;
        im   = 0;
        clip = 1'b0;
        if (n > 0)
        begin
            re = rho_re[0] * ONE_Q16;
            im = rho_im[0] * ONE_Q16;
            for (int i = 0; i + 1 < n; i++)
            begin
                w  = transition_weight(z - iface_depth[i], iface_sigma[i]);
                re = re + (rho_re[i + 1] - rho_re[i]) * w;
                im = im + (rho_im[i + 1] - rho_im[i]) * w;
            end
        end
        res.profile_real = round_clip(re, clip);
        res.profile_imag = round_clip(im, clip);
        res.saturated    = clip;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            layers_used = 0;
            profile_q.delete();
            errors  = 0;
            checked = 0;
            clipped = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                layers_used = cfg_wr_data;
            end
            if (in_valid && !in_stall)
            begin
                if (in_data.req_type == REQ_LOAD)
                begin
                    rho_re[in_data.entry_index]      = in_data.density_real;
                    rho_im[in_data.entry_index]      = in_data.density_imag;
                    iface_depth[in_data.entry_index] = in_data.bottom_depth;
                    iface_sigma[in_data.entry_index] = in_data.roughness;
                end
                else
                begin
                    profile_q = {profile_q, profile_at(longint'(in_data.depth_query))};
                end
            end
            if (out_valid && !out_stall)
            begin
                if (profile_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected profile result re=%0d im=%0d sat=%0b", $time,
                             out_data.profile_real, out_data.profile_imag, out_data.saturated);
                end
                else
                begin
                    want = profile_q.pop_front();
                    checked++;
                    if (want.saturated)
                    begin
                        clipped++;
                    end
                    if (out_data.profile_real !== want.profile_real
                        || out_data.profile_imag !== want.profile_imag
                        || out_data.saturated !== want.saturated)
                    begin
                        errors++;
                        $display("%0t: profile mismatch expected re=%0d im=%0d sat=%0b, got re=%0d im=%0d sat=%0b",
                                 $time, want.profile_real, want.profile_imag, want.saturated,
                                 out_data.profile_real, out_data.profile_imag, out_data.saturated);
                    end
                end
            end
        end
        pending = profile_q.size();
    end

endmodule

FILE: verif/tb_graded_interface_profile_core.sv
// Testbench top for the graded interface profile core: clock, reset, layer loads, depth
// queries, layer count settings and random stalls; the verdict comes from gip_profile_checker.
// Depends on gip_pkg, gip_profile_checker and the core RTL.
module tb_graded_interface_profile_core;
    import gip_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;

    logic      clk;
    logic      rst_n;
    logic      cfg_wr_en;
    logic [6:0] cfg_wr_data;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_data;

    int   errors;
    int   pending;
    int   checked;
    int   clipped;
    bit   quiet;
    bit   written [MAX_LAYERS];
    logic [31:0] depth_of [MAX_LAYERS];
    int   loads_sent;
    int   idle_cycles;
    int   stall_hold;

    graded_interface_profile_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

    gip_profile_checker i_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .errors     (errors),
        .pending    (pending),
        .checked    (checked),
        .clipped    (clipped)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n || quiet)
        begin
            out_stall  <= 1'b0;
            stall_hold = 0;
        end
        else if (stall_hold > 0)
        begin
            stall_hold--;
        end
        else
        begin
            out_stall  <= ($urandom_range(0, 2) == 0);
            stall_hold = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [31:0] pick_density();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return ($urandom_range(0, 1) == 1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($urandom_range(0, 32'h200000)) - 32'h100000;
        endcase
    endfunction

    function automatic logic [31:0] pick_depth();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return ($urandom_range(0, 1) == 1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($urandom_range(0, 32'h800000)) - 32'h400000;
        endcase
    endfunction

    function automatic logic [31:0] pick_sigma();
        case ($urandom_range(0, 9))
            0: return 32'h0;
            1: return 32'h80000000 | $urandom;
            2: return $urandom;
            3: return 32'h1;
            4: return 32'h7fffffff;
            default: return $urandom_range(1, 32'h40000);
        endcase
    endfunction

    function automatic in_item_t make_load(int idx);
        in_item_t it;
        it.req_type     = REQ_LOAD;
        it.entry_index  = 6'(idx);
        it.density_real = pick_density();
        it.density_imag = pick_density();
        it.bottom_depth = pick_depth();
        it.roughness    = pick_sigma();
        it.depth_query  = $urandom;
        return it;
    endfunction

    function automatic in_item_t make_query(int n);
        in_item_t it;
        it = make_load($urandom_range(0, MAX_LAYERS - 1));
        it.req_type = REQ_QUERY;
        if (n > 0 && $urandom_range(0, 9) < 7)
        begin
            it.depth_query = depth_of[$urandom_range(0, n - 1)]
                             + 32'($urandom_range(0, 32'h40000)) - 32'h20000;
        end
        else
        begin
            it.depth_query = $urandom;
        end
        return it;
    endfunction

    task automatic send(in_item_t it);
        int g;
        g = quiet ? 0 : pick_gap();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        if (it.req_type == REQ_LOAD)
        begin
            written[it.entry_index]  = 1'b1;
            depth_of[it.entry_index] = it.bottom_depth;
            loads_sent++;
        end
    endtask

    task automatic load_entry(int idx, logic [31:0] re, logic [31:0] im, logic [31:0] d,
                              logic [31:0] s);
        in_item_t it;
        it = make_load(idx);
        it.density_real = re;
        it.density_imag = im;
        it.bottom_depth = d;
        it.roughness    = s;
        send(it);
    endtask

    task automatic query_at(logic [31:0] z);
        in_item_t it;
        it = make_query(0);
        it.depth_query = z;
        send(it);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending != 0);
        repeat (50) @(posedge clk);
    endtask

    task automatic set_layers(logic [6:0] v);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic fill_missing(int n);
        for (int i = 0; i < n && i < MAX_LAYERS; i++)
        begin
            if (!written[i])
            begin
                send(make_load(i));
            end
        end
    endtask

    initial
    begin
        int counts [14];
        int n;
        int items;
        counts = '{2, 3, 64, 127, 5, 1, 0, 8, 65, 16, 4, 6, 3, 2};
        rst_n       = 1'b0;
        quiet       = 1'b0;
        loads_sent  = 0;
        idle_cycles = 0;
        stall_hold  = 0;
        in_valid    <= 1'b0;
        in_data     <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        out_stall   <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_layers(7'd0);
        query_at(32'h0);
        query_at(32'h7fffffff);
        load_entry(0, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h0);
        load_entry(1, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'hffffffff);
        load_entry(2, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
        load_entry(3, 32'h7fffffff, 32'h80000000, 32'h0, 32'h10000);
        load_entry(4, 32'h12345, 32'hfffedcba, 32'h10000, 32'h1);
        load_entry(5, 32'h0, 32'h0, 32'h20000, 32'h7fffffff);
        load_entry(63, 32'hffffffff, 32'h1, 32'h80000000, 32'h8000);
        set_layers(7'd1);
        query_at(32'h80000000);
        query_at(32'h7fffffff);
        set_layers(7'd4);
        query_at(32'h0);
        query_at(32'h80000000);
        query_at(32'h7fffffff);
        set_layers(7'd6);
        query_at(32'h0);
        query_at(32'h8000);
        query_at(32'hffff8000);
        query_at(32'h10000);
        query_at(32'h20000);

        foreach (counts[p])
        begin
            n = (counts[p] > MAX_LAYERS) ? MAX_LAYERS : counts[p];
            set_layers(7'(counts[p]));
            quiet = (p % 4 == 3);
            fill_missing(n);
            items = (n >= 16) ? 30 : 100;
            for (int k = 0; k < items; k++)
            begin
                if ($urandom_range(0, 99) < 35)
                begin
                    if (n > 0 && $urandom_range(0, 3) != 0)
                    begin
                        send(make_load($urandom_range(0, n - 1)));
                    end
                    else
                    begin
                        send(make_load($urandom_range(0, MAX_LAYERS - 1)));
                    end
                end
                else
                begin
                    send(make_query(n));
                end
            end
            quiet = 1'b0;
        end

        wait_idle();
        $display("Run covered %0d layer loads and %0d checked profile queries, %0d of them clipped,",
                 loads_sent, checked, clipped);
        $display("over layer counts from 0 to 127 with random stalls on both channels.");
        if (errors == 0 && pending == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: graded_interface_profile_core.f
+incdir+rtl
rtl/gip_pkg.sv
rtl/gip_ram.sv
rtl/gip_weight.sv
rtl/graded_interface_profile_core.sv
verif/gip_profile_checker.sv
verif/tb_graded_interface_profile_core.sv
